@@ rtl/core/conv2d_pkg.sv @@
// Shared types, constants and helper functions of the multi-channel convolution block.
package conv2d_pkg;

    localparam int MAX_KERNELS  = 8;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_IMAGE    = 32;
    localparam int MAX_KSIZE    = 5;

    localparam int KIND_W     = 2;
    localparam int KERN_W     = 3;
    localparam int CH_W       = 2;
    localparam int POS_W      = 5;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 40;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int KSZ_W      = 3;
    localparam int IMG_W      = 6;
    localparam int NCH_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int TAP_W      = 8;
    localparam int BIAS_SHIFT = 8;

    localparam int WMEM_DEPTH = MAX_KERNELS * MAX_CHANNELS * MAX_KSIZE * MAX_KSIZE;
    localparam int WADDR_W    = $clog2(WMEM_DEPTH);
    localparam int PMEM_DEPTH = MAX_CHANNELS * MAX_IMAGE * MAX_IMAGE;
    localparam int PADDR_W    = CH_W + 2 * POS_W;
    localparam int DRAIN_CYCLES = 2;
    localparam int DRAIN_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_BIAS    = 2'd1,
        KIND_PIXEL   = 2'd2,
        KIND_COMPUTE = 2'd3
    } kind_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_ROWS = 3'd0,
        CFG_KERNEL_COLS = 3'd1,
        CFG_IMAGE_ROWS  = 3'd2,
        CFG_IMAGE_COLS  = 3'd3,
        CFG_CHANNELS    = 3'd4,
        CFG_SAME_BORDER = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [KERN_W-1:0]       kernel_index;
        logic [CH_W-1:0]         channel;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    status;
        logic [KERN_W-1:0]       out_kernel;
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;
        logic latch_req;
        logic step;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_ok;
        logic last_tap;
    } stat_t;

    // Kernel size register to the odd tap count in 1..MAX_KSIZE.
    function automatic logic [KSZ_W-1:0] odd_ksize(input logic [KSZ_W-1:0] v);
        logic [KSZ_W-1:0] s;
        if (v == '0)
            s = KSZ_W'(1);
        else if (v > KSZ_W'(MAX_KSIZE))
            s = KSZ_W'(MAX_KSIZE);
        else
            s = v;
        if (!s[0])
            s = s - KSZ_W'(1);
        return s;
    endfunction

    function automatic logic [IMG_W-1:0] clamp_img(input logic [IMG_W-1:0] v);
        logic [IMG_W-1:0] s;
        if (v == '0)
            s = IMG_W'(1);
        else if (v > IMG_W'(MAX_IMAGE))
            s = IMG_W'(MAX_IMAGE);
        else
            s = v;
        return s;
    endfunction

    function automatic logic [NCH_W-1:0] clamp_ch(input logic [NCH_W-1:0] v);
        logic [NCH_W-1:0] s;
        if (v == '0)
            s = NCH_W'(1);
        else if (v > NCH_W'(MAX_CHANNELS))
            s = NCH_W'(MAX_CHANNELS);
        else
            s = v;
        return s;
    endfunction

    // Flat weight address: kernel, channel, tap row, tap column.
    function automatic logic [WADDR_W-1:0] weight_addr(input logic [KERN_W-1:0] k,
                                                       input logic [CH_W-1:0]   m,
                                                       input logic [KSZ_W-1:0]  r,
                                                       input logic [KSZ_W-1:0]  c);
        logic [WADDR_W-1:0] t;
        t = WADDR_W'({k, m}) * WADDR_W'(MAX_KSIZE) + WADDR_W'(r);
        t = t * WADDR_W'(MAX_KSIZE) + WADDR_W'(c);
        return t;
    endfunction

endpackage

@@ rtl/core/conv2d_ctrl.sv @@
// Controller state machine: handshakes, request sequencing and result hand-off.
module conv2d_ctrl
    import conv2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [KIND_W-1:0] req_kind,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  stat_t             stat,
    output cmd_t              cmd
);

    state_t             state_reg, state_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               accept;
    logic               out_free;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drain_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_kind == KIND_COMPUTE)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = stat.req_ok ? ST_RUN : ST_FINISH;
            end
            ST_RUN:
            begin
                drain_next = '0;
                if (stat.last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_stall       = (state_reg != ST_IDLE);
        cmd.wr_en       = 1'b0;
        cmd.latch_req   = 1'b0;
        cmd.step        = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_en     = accept;
                cmd.latch_req = accept && req_kind == KIND_COMPUTE;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
                cmd.step = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_result)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/core/conv2d_dp.sv @@
// Datapath: configuration, weight/bias/pixel stores, tap walker and multiply-accumulate.
module conv2d_dp
    import conv2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              req,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output out_item_t             rsp
);

    // Configuration registers.
    logic [KSZ_W-1:0] krows_reg, kcols_reg;
    logic [IMG_W-1:0] irows_reg, icols_reg;
    logic [NCH_W-1:0] nch_reg;
    logic             same_reg;

    // Stores.
    logic [VAL_W-1:0] wmem [WMEM_DEPTH];
    logic [VAL_W-1:0] pmem [PMEM_DEPTH];
    logic [VAL_W-1:0] bias_mem [MAX_KERNELS];

    // Request and tap counters.
    logic [KERN_W-1:0] kern_reg;
    logic [POS_W-1:0]  row_reg, col_reg;
    logic [CH_W-1:0]   m_reg;
    logic [KSZ_W-1:0]  a_reg, b_reg;

    // Pipeline.
    logic [VAL_W-1:0]         w_rd_reg, p_rd_reg;
    logic                     vld1_reg, vld2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    out_item_t                rsp_reg;

    logic [KSZ_W-1:0]        kr, kc, hr, hc;
    logic [IMG_W-1:0]        ir, ic;
    logic [NCH_W-1:0]        nch;
    logic [IMG_W-1:0]        row_span, col_span;
    logic signed [TAP_W-1:0] pr, pc;
    logic                    tap_in;
    logic [WADDR_W-1:0]      waddr;
    logic [PADDR_W-1:0]      paddr;
    logic                    last_b, last_a, last_m;
    logic [VAL_W-1:0]        bias_val;
    logic signed [SUM_W-1:0] bias_term;

    always_comb
    begin
        kr  = odd_ksize(krows_reg);
        kc  = odd_ksize(kcols_reg);
        hr  = kr >> 1;
        hc  = kc >> 1;
        ir  = clamp_img(irows_reg);
        ic  = clamp_img(icols_reg);
        nch = clamp_ch(nch_reg);
    end

    // In valid mode the last kernel tap must still land inside the image.
    always_comb
    begin
        row_span = IMG_W'(row_reg) + (same_reg ? '0 : IMG_W'(kr - KSZ_W'(1)));
        col_span = IMG_W'(col_reg) + (same_reg ? '0 : IMG_W'(kc - KSZ_W'(1)));
        stat.req_ok = (row_span < ir) && (col_span < ic);
    end

    always_comb
    begin
        last_b = (b_reg == kc - KSZ_W'(1));
        last_a = (a_reg == kr - KSZ_W'(1));
        last_m = (NCH_W'(m_reg) == nch - NCH_W'(1));
        stat.last_tap = last_b && last_a && last_m;
    end

    // Pixel position of the current tap; same mode centers the kernel on the output.
    always_comb
    begin
        pr = $signed(TAP_W'(row_reg)) + $signed(TAP_W'(a_reg))
             - (same_reg ? $signed(TAP_W'(hr)) : $signed(TAP_W'(0)));
        pc = $signed(TAP_W'(col_reg)) + $signed(TAP_W'(b_reg))
             - (same_reg ? $signed(TAP_W'(hc)) : $signed(TAP_W'(0)));
        tap_in = (pr >= 0) && (pc >= 0) && (pr < $signed(TAP_W'(ir)))
                 && (pc < $signed(TAP_W'(ic)));
        paddr = {m_reg, pr[POS_W-1:0], pc[POS_W-1:0]};
        // The kernel is flipped in both directions.
        waddr = weight_addr(kern_reg, m_reg, kr - KSZ_W'(1) - a_reg, kc - KSZ_W'(1) - b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krows_reg <= KSZ_W'(3);
            kcols_reg <= KSZ_W'(3);
            irows_reg <= IMG_W'(MAX_IMAGE);
            icols_reg <= IMG_W'(MAX_IMAGE);
            nch_reg   <= NCH_W'(1);
            same_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_KERNEL_ROWS: krows_reg <= cfg_data[KSZ_W-1:0];
                CFG_KERNEL_COLS: kcols_reg <= cfg_data[KSZ_W-1:0];
                CFG_IMAGE_ROWS:  irows_reg <= cfg_data[IMG_W-1:0];
                CFG_IMAGE_COLS:  icols_reg <= cfg_data[IMG_W-1:0];
                CFG_CHANNELS:    nch_reg   <= cfg_data[NCH_W-1:0];
                CFG_SAME_BORDER: same_reg  <= cfg_data[0];
                default:         same_reg  <= same_reg;
            endcase
        end
    end

    // Store writes.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && req.kind == KIND_WEIGHT && req.row < POS_W'(MAX_KSIZE)
            && req.col < POS_W'(MAX_KSIZE))
            wmem[weight_addr(req.kernel_index, req.channel, req.row[KSZ_W-1:0],
                             req.col[KSZ_W-1:0])] <= req.value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && req.kind == KIND_PIXEL)
            pmem[{req.channel, req.row, req.col}] <= req.value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && req.kind == KIND_BIAS)
            bias_mem[req.kernel_index] <= req.value;
    end

    // Registered store reads.
    always_ff @(posedge clk)
    begin
        w_rd_reg <= wmem[waddr];
        p_rd_reg <= pmem[paddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            kern_reg <= req.kernel_index;
            row_reg  <= req.row;
            col_reg  <= req.col;
        end
    end

    // Tap walker: column fastest, then row, then channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (cmd.latch_req)
        begin
            m_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (last_b)
            begin
                b_reg <= '0;
                if (last_a)
                begin
                    a_reg <= '0;
                    m_reg <= m_reg + CH_W'(1);
                end
                else
                    a_reg <= a_reg + KSZ_W'(1);
            end
            else
                b_reg <= b_reg + KSZ_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= cmd.step && tap_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(w_rd_reg) * $signed(p_rd_reg);
    end

    // At most 100 products of magnitude 2^30 plus the bias stay far inside 40 bits,
    // so the sum never reaches the saturation limits.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
            acc_reg <= '0;
        else if (vld2_reg)
            acc_reg <= acc_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    assign bias_val  = bias_mem[kern_reg];
    assign bias_term = {{(SUM_W-VAL_W-BIAS_SHIFT){bias_val[VAL_W-1]}}, bias_val,
                        {BIAS_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            rsp_reg.sum        <= stat.req_ok ? acc_reg + bias_term : '0;
            rsp_reg.status     <= !stat.req_ok;
            rsp_reg.out_kernel <= kern_reg;
            rsp_reg.out_row    <= row_reg;
            rsp_reg.out_col    <= col_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ rtl/core/conv2d_multi_channel.sv @@
// Top level of the multi-channel 2D convolution block.
//
// This block holds up to 8 kernels of up to 5x5 taps over up to 4 channels, one bias
// per kernel and a 4-channel 32x32 image, all signed Q8.8, and returns one signed
// Q24.16 output sample per compute transaction: the true (flipped-kernel) convolution
// of the selected kernel with the image, summed over the configured channels, plus
// the kernel's bias. Weight, bias and pixel write transactions can be taken back to
// back and produce no result; a weight write whose tap row or column lies beyond the
// kernel store is dropped. Stores are not cleared by reset, so each entry must be
// written before a compute reads it. In valid mode the output map is the image
// shrunk by the kernel margin; in same mode it has the image size and taps outside
// the image are skipped. A compute transaction whose position lies outside the
// output map skips the tap walk and presents status 1 and a zero sum. A good one
// walks all taps through a single 16x16 multiplier, one tap per cycle, then drains
// the pipeline. The next request is taken once the result has been loaded into the
// output register, where it waits while further write transactions are taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write
// it only while the block is idle, and the block itself has no guard for this.
// Out-of-range sizes are clamped and even kernel sizes round down.
module conv2d_multi_channel
    import conv2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  in_item_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output out_item_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // The controller owns both handshakes and steps the datapath through the taps.
    conv2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds configuration, the stores and the multiply-accumulate pipe.
    conv2d_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

@@ rtl/core/conv2d_chk.sv @@
// Port-level checker for the convolution block, bound to the top level.
module conv2d_chk
    import conv2d_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input in_item_t  req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input out_item_t rsp
);

    // An error result always carries a zero sum.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> rsp.sum == '0)
        else $error("error result with nonzero sum");

    // A compute transaction occupies the block on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.kind == KIND_COMPUTE |=> req_stall)
        else $error("compute request did not make the block busy");

    // A store write never creates a result.
    a_wr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.kind != KIND_COMPUTE && !rsp_valid |=> !rsp_valid)
        else $error("result appeared after a write");

    // A new result only comes out of a busy period.
    a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without a compute");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind conv2d_multi_channel conv2d_chk u_chk (.*);

@@ verif/conv2d_multi_channel_test.sv @@
// Self-checking testbench for the multi-channel 2D convolution block.
module conv2d_multi_channel_test;
    import conv2d_pkg::*;

    // Stimulus stops once this many non-ignored transactions have been queued.
    localparam int ITEM_TARGET = 1650;
    // Longest random wait either side inserts for one transaction.
    localparam int GAP_MAX = 18;
    // A correct run is never quiet for long: the slowest compute, the longest random waits
    // of sender and receiver, and the settling and configuration between phases all fit
    // many times over into this limit.
    localparam int IDLE_LIMIT = 2000;
    // Cycles allowed after the last result before touching the configuration.
    localparam int SETTLE_CYCLES = 8;
    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -SUM_HI - 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    in_item_t              req = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    out_item_t             rsp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: a private copy of the three stores and the raw register values.
    logic signed [VAL_W-1:0] weight_mem [MAX_KERNELS][MAX_CHANNELS][MAX_KSIZE][MAX_KSIZE];
    logic signed [VAL_W-1:0] bias_mem [MAX_KERNELS];
    logic signed [VAL_W-1:0] pixel_mem [MAX_CHANNELS][MAX_IMAGE][MAX_IMAGE];
    logic [KSZ_W-1:0] kern_rows_reg = KSZ_W'(3);
    logic [KSZ_W-1:0] kern_cols_reg = KSZ_W'(3);
    logic [IMG_W-1:0] img_rows_reg = IMG_W'(32);
    logic [IMG_W-1:0] img_cols_reg = IMG_W'(32);
    logic [NCH_W-1:0] chan_reg = NCH_W'(1);
    logic             same_reg = 1'b0;

    // Stimulus-side bookkeeping of which store entries have been written. A compute
    // is only queued once every entry it reads has a write queued ahead of it.
    bit weight_seen [MAX_KERNELS][MAX_CHANNELS][MAX_KSIZE][MAX_KSIZE];
    bit bias_seen [MAX_KERNELS];
    bit pixel_seen [MAX_CHANNELS][MAX_IMAGE][MAX_IMAGE];

    in_item_t  pending_items[$];
    out_item_t expected_samples[$];
    int        item_count = 0;
    int        mismatch_count = 0;

    // Per-side random wait counters; each side has a calm mode with no waits at all,
    // which it toggles now and then so that long back-to-back stretches also occur.
    int gap_left = 0;
    int stall_left = 0;
    bit req_calm = 1'b0;
    bit rsp_calm = 1'b0;
    int quiet_cycles = 0;

    conv2d_multi_channel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // Kernel sizes clamp to 1..MAX_KSIZE and an even size drops to the odd one below.
    function automatic int odd_taps(input int v);
        int s;
        s = (v < 1) ? 1 : ((v > MAX_KSIZE) ? MAX_KSIZE : v);
        if (s % 2 == 0)
            s = s - 1;
        return s;
    endfunction

    function automatic int limit_to(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Effective sizes and output map dimensions for the current register values.
    // In valid mode the map loses the kernel margin, and it is empty when the kernel
    // is larger than the image.
    function automatic void geometry(output int kr, output int kc, output int ir,
                                     output int ic, output int nch, output int orows,
                                     output int ocols);
        kr  = odd_taps(kern_rows_reg);
        kc  = odd_taps(kern_cols_reg);
        ir  = limit_to(img_rows_reg, MAX_IMAGE);
        ic  = limit_to(img_cols_reg, MAX_IMAGE);
        nch = limit_to(chan_reg, MAX_CHANNELS);
        if (same_reg) begin
            orows = ir;
            ocols = ic;
        end
        else begin
            orows = (ir >= kr - 1) ? ir - (kr - 1) : 0;
            ocols = (ic >= kc - 1) ? ic - (kc - 1) : 0;
        end
    endfunction

    // Predictor: updates the stores for a write transaction, or computes the expected
    // output sample of a compute transaction and queues it.
    function automatic void apply_transaction(input in_item_t t);
        int        kr, kc, ir, ic, nch, orows, ocols;
        int        r, c, pr, pc, k;
        longint    acc;
        out_item_t res;
        r = t.row;
        c = t.col;
        k = t.kernel_index;
        case (kind_e_t'(t.kind))
            KIND_WEIGHT:
                if (r < MAX_KSIZE && c < MAX_KSIZE)
                    weight_mem[k][t.channel][r][c] = t.value;
            KIND_BIAS:
                bias_mem[k] = t.value;
            KIND_PIXEL:
                pixel_mem[t.channel][r][c] = t.value;
            default:
            begin
                geometry(kr, kc, ir, ic, nch, orows, ocols);
                res = '0;
                res.out_kernel = t.kernel_index;
                res.out_row = t.row;
                res.out_col = t.col;
                if (r >= orows || c >= ocols) begin
                    // Position outside the output map: error status and a zero sum.
                    res.status = 1'b1;
                end
                else begin
                    acc = 0;
                    for (int m = 0; m < nch; m++) begin
                        for (int a = 0; a < kr; a++) begin
                            for (int b = 0; b < kc; b++) begin
                                pr = same_reg ? r - (kr - 1) / 2 + a : r + a;
                                pc = same_reg ? c - (kc - 1) / 2 + b : c + b;
                                // In same mode taps that fall off the image are skipped.
                                if (pr >= 0 && pc >= 0 && pr < ir && pc < ic)
                                    acc += longint'(weight_mem[k][m][kr - 1 - a][kc - 1 - b]) *
                                           longint'(pixel_mem[m][pr][pc]);
                            end
                        end
                    end
                    // The Q8.8 bias is aligned to the Q24.16 sum.
                    acc += longint'(bias_mem[k]) * 256;
                    if (acc > SUM_HI)
                        acc = SUM_HI;
                    if (acc < SUM_LO)
                        acc = SUM_LO;
                    res.sum = acc[SUM_W-1:0];
                end
                expected_samples.insert(expected_samples.size(), res);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Queues one transaction for the driver and records which store entry it fills.
    // A weight write beyond the tap store is dropped by the block and is not counted.
    function automatic void post_item(input kind_e_t kind, input int k, input int ch,
                                      input int r, input int c, input logic [VAL_W-1:0] v);
        in_item_t t;
        t.kind = kind;
        t.kernel_index = KERN_W'(k);
        t.channel = CH_W'(ch);
        t.row = POS_W'(r);
        t.col = POS_W'(c);
        t.value = v;
        pending_items.insert(pending_items.size(), t);
        case (kind)
            KIND_WEIGHT:
                if (r < MAX_KSIZE && c < MAX_KSIZE)
                    weight_seen[k][ch][r][c] = 1'b1;
            KIND_BIAS:
                bias_seen[k] = 1'b1;
            KIND_PIXEL:
                pixel_seen[ch][r][c] = 1'b1;
            default: ;
        endcase
        if (!(kind == KIND_WEIGHT && (r >= MAX_KSIZE || c >= MAX_KSIZE)))
            item_count++;
    endfunction

    // Mostly random data, with both extremes of the signed Q8.8 range showing up often.
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Queues a compute transaction. For a position inside the output map, the bias,
    // every kernel tap of every summed channel and every pixel in the window that has
    // not been written yet is loaded first with random data.
    function automatic void queue_compute(input int k, input int r, input int c);
        int kr, kc, ir, ic, nch, orows, ocols, pr, pc;
        geometry(kr, kc, ir, ic, nch, orows, ocols);
        if (r < orows && c < ocols) begin
            if (!bias_seen[k])
                post_item(KIND_BIAS, k, $urandom_range(0, 3), $urandom_range(0, 31),
                          $urandom_range(0, 31), rand_value());
            for (int m = 0; m < nch; m++) begin
                for (int a = 0; a < kr; a++) begin
                    for (int b = 0; b < kc; b++) begin
                        if (!weight_seen[k][m][a][b])
                            post_item(KIND_WEIGHT, k, m, a, b, rand_value());
                        pr = same_reg ? r - (kr - 1) / 2 + a : r + a;
                        pc = same_reg ? c - (kc - 1) / 2 + b : c + b;
                        if (pr >= 0 && pc >= 0 && pr < ir && pc < ic && !pixel_seen[m][pr][pc])
                            post_item(KIND_PIXEL, $urandom_range(0, 7), m, pr, pc, rand_value());
                    end
                end
            end
        end
        post_item(KIND_COMPUTE, k, $urandom_range(0, 3), r, c, VAL_W'($urandom));
    endfunction

    // Unstructured traffic: overwrites anywhere in the stores, dropped weight writes
    // with tap positions past the store, and computes at arbitrary positions.
    function automatic void queue_noise();
        int r, c;
        case ($urandom_range(0, 3))
            0:
            begin
                r = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
                c = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
                post_item(KIND_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 3), r, c,
                          rand_value());
            end
            1: post_item(KIND_BIAS, $urandom_range(0, 7), $urandom_range(0, 3),
                         $urandom_range(0, 31), $urandom_range(0, 31), rand_value());
            2: post_item(KIND_PIXEL, $urandom_range(0, 7), $urandom_range(0, 3),
                         $urandom_range(0, 31), $urandom_range(0, 31), rand_value());
            default: queue_compute($urandom_range(0, 7), $urandom_range(0, 31),
                                   $urandom_range(0, 31));
        endcase
    endfunction

    // Output positions mostly cluster in the top-left corner so that big images
    // do not need thousands of pixel loads; now and then anywhere in the map.
    function automatic int pick_pos(input int span);
        int reach;
        if (span == 0)
            return $urandom_range(0, 31);
        reach = (span < 6) ? span : 6;
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(0, reach - 1);
        return $urandom_range(0, span - 1);
    endfunction

    // Raw register values: mostly legal sizes, sometimes anything the field holds so
    // that clamping and the even-size rounding are exercised.
    function automatic int pick_ksize();
        int odd_sizes [3] = '{1, 3, 5};
        if ($urandom_range(0, 9) < 7)
            return odd_sizes[$urandom_range(0, 2)];
        return $urandom_range(0, 7);
    endfunction

    function automatic int pick_isize();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return $urandom_range(1, 10);
        if (sel < 17)
            return MAX_IMAGE;
        return $urandom_range(0, 63);
    endfunction

    function automatic int pick_chans();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, MAX_CHANNELS);
        return $urandom_range(0, 7);
    endfunction

    // One register write; the block is idle whenever this is called, so the
    // predictor's copy can follow at once.
    task automatic write_reg(input cfg_idx_t idx, input int data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(data);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KERNEL_ROWS: kern_rows_reg = KSZ_W'(data);
            CFG_KERNEL_COLS: kern_cols_reg = KSZ_W'(data);
            CFG_IMAGE_ROWS:  img_rows_reg = IMG_W'(data);
            CFG_IMAGE_COLS:  img_cols_reg = IMG_W'(data);
            CFG_CHANNELS:    chan_reg = NCH_W'(data);
            CFG_SAME_BORDER: same_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int kr, input int kc, input int ir, input int ic,
                              input int nch, input int same);
        write_reg(CFG_KERNEL_ROWS, kr);
        write_reg(CFG_KERNEL_COLS, kc);
        write_reg(CFG_IMAGE_ROWS, ir);
        write_reg(CFG_IMAGE_COLS, ic);
        write_reg(CFG_CHANNELS, nch);
        write_reg(CFG_SAME_BORDER, same);
    endtask

    // Holds the sender until everything queued has been taken and every expected
    // sample has come back, then lets the block settle. Sampled on the falling edge
    // so that the driver's and monitor's updates are already visible.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One configuration phase of random traffic. Most of it is well-formed: load
    // whatever the window needs, then ask for an output inside the map. The rest is
    // requests outside the map and unstructured noise.
    task automatic run_phase();
        int kr, kc, ir, ic, nch, orows, ocols;
        int n, sel, k, r, c, home_kernel;
        geometry(kr, kc, ir, ic, nch, orows, ocols);
        n = $urandom_range(10, 30);
        // Stick to one kernel per phase most of the time; a full 5x5x4 kernel is
        // a hundred weight loads.
        home_kernel = $urandom_range(0, 7);
        repeat (n) begin
            sel = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : home_kernel;
            if (sel < 70) begin
                queue_compute(k, pick_pos(orows), pick_pos(ocols));
            end
            else if (sel < 82) begin
                if (orows < MAX_IMAGE) begin
                    r = $urandom_range(orows, 31);
                    c = $urandom_range(0, 31);
                end
                else if (ocols < MAX_IMAGE) begin
                    r = pick_pos(orows);
                    c = $urandom_range(ocols, 31);
                end
                else begin
                    r = pick_pos(orows);
                    c = pick_pos(ocols);
                end
                queue_compute(k, r, c);
            end
            else begin
                queue_noise();
            end
        end
    endtask

    // Driver: presents queued transactions, with a random number of idle cycles
    // after each one. A stalled payload is held as it is.
    always @(posedge clk or negedge rst_n) begin : req_driver
        if (!rst_n) begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
        end
        else begin
            if (req_valid && !req_stall)
                apply_transaction(req);
            if (!req_valid || !req_stall) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    req <= pending_items.pop_front();
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 99) < 4)
                        req_calm = !req_calm;
                    gap_left = draw_wait(req_calm);
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expected sample, then
    // draws how long to stall the next one. The stall counts down only while a
    // result is waiting, so the back-pressure actually lands on the output register.
    always @(posedge clk or negedge rst_n) begin : rsp_monitor
        out_item_t want;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result: kernel %0d row %0d col %0d sum %0d",
                           rsp.out_kernel, rsp.out_row, rsp.out_col, rsp.sum);
                    mismatch_count++;
                end
                else begin
                    want = expected_samples.pop_front();
                    check_field("sum", want.sum, rsp.sum);
                    check_field("status", want.status, rsp.status);
                    check_field("out_kernel", want.out_kernel, rsp.out_kernel);
                    check_field("out_row", want.out_row, rsp.out_row);
                    check_field("out_col", want.out_col, rsp.out_col);
                end
                if ($urandom_range(0, 99) < 4)
                    rsp_calm = !rsp_calm;
                stall_left = draw_wait(rsp_calm);
            end
            else if (rsp_valid && stall_left != 0) begin
                stall_left = stall_left - 1;
            end
            rsp_stall <= (stall_left != 0);
        end
    end

    // Watchdog: any cycle with a transaction on either channel or a register write
    // counts as progress; a long quiet stretch means the block has hung.
    always @(posedge clk) begin : watchdog
        if (!rst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
        end
        else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("conv2d_multi_channel_test: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset configuration (3x3 kernel, 32x32 image,
        // one channel, valid mode, so the map is 30x30). Kernel 7 is loaded with
        // full-scale negative and positive weights against the bottom-right corner
        // of the image, all pixels at the most negative value, then read at the last
        // in-map position. A weight write past the tap store must be dropped, and
        // requests just outside the map and at the far corner must report status 1.
        @(negedge clk);
        post_item(KIND_BIAS, 7, 0, 0, 0, 16'h8000);
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                post_item(KIND_WEIGHT, 7, 0, a, b, ((a + b) % 2 != 0) ? 16'h7fff : 16'h8000);
                post_item(KIND_PIXEL, 0, 0, 29 + a, 29 + b, 16'h8000);
            end
        end
        post_item(KIND_WEIGHT, 7, 0, 7, 31, 16'h1234);
        post_item(KIND_COMPUTE, 7, 3, 29, 29, 16'hffff);
        post_item(KIND_COMPUTE, 0, 0, 30, 5, 16'h0000);
        post_item(KIND_COMPUTE, 3, 1, 0, 31, 16'h0000);
        post_item(KIND_COMPUTE, 7, 2, 31, 31, 16'h8000);

        // Random phases. The first few pin the register extremes: everything at its
        // largest in same mode; out-of-range raw values that clamp to a kernel taller
        // than a one-row image in valid mode (an empty map); everything at its
        // smallest; and even kernel sizes with oversized image and zero channels.
        // Each phase boundary also holds the sender until all results are back.
        phase = 0;
        while (item_count < ITEM_TARGET) begin
            wait_drained();
            case (phase)
                0: set_config(MAX_KSIZE, MAX_KSIZE, MAX_IMAGE, MAX_IMAGE, MAX_CHANNELS, 1);
                1: set_config(7, 0, 0, 63, 7, 0);
                2: set_config(1, 1, 1, 1, 1, 0);
                3: set_config(2, 4, 33, 40, 0, 1);
                default: set_config(pick_ksize(), pick_ksize(), pick_isize(), pick_isize(),
                                    pick_chans(), $urandom_range(0, 1));
            endcase
            @(negedge clk);
            run_phase();
            phase++;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("conv2d_multi_channel_test: PASS");
        else
            $display("conv2d_multi_channel_test: FAIL");
        $finish;
    end

endmodule
